/* hw/rtl/f2h_pkg.sv */
// Package with shared types and the float32 to float16 conversion function.
package f2h_pkg;

  localparam int SingleW = 32;
  localparam int HalfW   = 16;

  typedef struct packed {
    logic [HalfW-1:0] half;
    logic             lossy;
  } conv_res_t;

  function automatic conv_res_t to_half(input logic [SingleW-1:0] x);
    conv_res_t   res;
    logic [15:0] sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [9:0]  keep;
    logic [12:0] rem;
    logic [15:0] h;
    logic [23:0] sig;
    logic [4:0]  s;
    logic [23:0] q;
    logic [23:0] r;
    logic [23:0] hlf;
    logic [23:0] msk;
    sgn = {x[31], 15'd0};
    e   = x[30:23];
    m   = x[22:0];
    res.lossy = 1'b0;
    res.half  = sgn;
    keep = m[22:13];
    rem  = m[12:0];
    sig  = {1'b1, m};
    s    = 5'(8'd126 - e);
    q    = sig >> s;
    msk  = (24'd1 << s) - 24'd1;
    r    = sig & msk;
    hlf  = 24'd1 << (s - 5'd1);
    h    = {1'b0, 5'(e - 8'd112), keep};
    if (e == 8'hFF) begin
      if (m == 23'd0) begin
        res.half = sgn | 16'h7C00;
      end else begin
        res.half = sgn | 16'h7E00 | {6'd0, m[22:13]};
      end
    end else if (e == 8'd0) begin
      res.lossy = (m != 23'd0);
    end else if (e >= 8'd143) begin
      res.lossy = 1'b1;
      res.half  = sgn | 16'h7C00;
    end else if (e >= 8'd113) begin
      if (rem > 13'h1000 || (rem == 13'h1000 && keep[0])) begin
        h = h + 16'd1;
      end
      res.lossy = (rem != 13'd0);
      res.half  = sgn | h;
    end else if (e < 8'd102) begin
      res.lossy = 1'b1;
    end else begin
      if (r > hlf || (r == hlf && q[0])) begin
        q = q + 24'd1;
      end
      res.lossy = (r != 24'd0);
      res.half  = sgn | q[15:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/fp32_to_fp16_with_exact_flag.sv */
// Top level of the streaming float32 to float16 converter with run exactness flag.
// Channel | Direction | Ports
// in_     | input     | in_valid, in_ready, in_single_value, in_last
// out_    | output    | out_valid, out_ready, out_half_value, out_run_exact, out_end_of_run
// A request is registered at the input, converted in one pass, and held in the result register.
// One request per cycle is sustained while out_ready is high.
// The input stage advances whenever it is empty or the result register is empty or being drained.
// Reset clears both valid flags and the sticky inexact bit.
module fp32_to_fp16_with_exact_flag (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [f2h_pkg::SingleW-1:0] in_single_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [f2h_pkg::HalfW-1:0]   out_half_value,
  output logic                        out_run_exact,
  output logic                        out_end_of_run
);
  import f2h_pkg::*;

  logic               s1_valid_r;
  logic [SingleW-1:0] s1_val_r;
  logic               s1_last_r;
  logic               out_valid_r;
  logic [HalfW-1:0]   half_r;
  logic               exact_r;
  logic               eor_r;
  logic               sticky_r;
  logic               sticky_nxt;
  logic               adv_out;
  logic               adv_in;
  conv_res_t          res;

  f2h_conv u_conv (
    .single_value (s1_val_r),
    .res          (res)
  );

  assign adv_out  = !out_valid_r || out_ready;
  assign adv_in   = !s1_valid_r || adv_out;
  assign in_ready = adv_in;

  always_comb begin
    sticky_nxt = sticky_r | res.lossy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
    end else begin
      if (adv_in) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          sticky_r <= s1_last_r ? 1'b0 : sticky_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_val_r  <= in_single_value;
      s1_last_r <= in_last;
    end
    if (adv_out && s1_valid_r) begin
      half_r  <= res.half;
      exact_r <= s1_last_r && !sticky_nxt;
      eor_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_half_value = half_r;
  assign out_run_exact  = exact_r;
  assign out_end_of_run = eor_r;

endmodule

/* hw/rtl/f2h_conv.sv */
// Combinational conversion of one registered single word to half with a loss flag.
module f2h_conv (
  input  logic [f2h_pkg::SingleW-1:0] single_value,
  output f2h_pkg::conv_res_t          res
);
  import f2h_pkg::*;

  assign res = to_half(single_value);

endmodule

/* hw/rtl/f2h_checker.sv */
// Port-level checker for the converter, bound to the top level.
module f2h_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_half_value,
  input logic        out_run_exact,
  input logic        out_end_of_run
);

  a_exact_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_run_exact || out_end_of_run))
    else $error("run_exact set on a request that is not last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_half_value))
    else $error("stalled result changed");

  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fp32_to_fp16_with_exact_flag f2h_props u_f2h_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_half_value (out_half_value),
  .out_run_exact  (out_run_exact),
  .out_end_of_run (out_end_of_run)
);
